// File: hdl/asrc_pkg.sv
// ----------------------------------------------------------------------------
// asrc_pkg
// token kinds, error codes and byte classes of the assembly source tokenizer
// ----------------------------------------------------------------------------
package asrc_pkg;

  typedef enum logic [4:0] {
    TK_KEY     = 5'd0,
    TK_LABEL   = 5'd1,
    TK_DOLLAR  = 5'd2,
    TK_DDOLLAR = 5'd3,
    TK_NUM     = 5'd4,
    TK_STR     = 5'd5,
    TK_LNEND   = 5'd6,
    TK_SEP     = 5'd7,
    TK_DIV     = 5'd8,
    TK_DOT     = 5'd9,
    TK_LBRACK  = 5'd10,
    TK_RBRACK  = 5'd11,
    TK_LPAREN  = 5'd12,
    TK_RPAREN  = 5'd13,
    TK_ADD     = 5'd14,
    TK_SUB     = 5'd15,
    TK_MUL     = 5'd16,
    TK_COLON   = 5'd17,
    TK_RAR     = 5'd18,
    TK_END     = 5'd19,
    TK_ERROR   = 5'd20
  } tok_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_INVALID = 3'd1,
    ERR_LONE_GT = 3'd2,
    ERR_UNTERM  = 3'd3,
    ERR_DOT2    = 3'd4
  } tok_err_e;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChLowH   = 8'h68;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChUpX    = 8'h58;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSemi   = 8'h3b;
  localparam logic [7:0] ChGt     = 8'h3e;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChUnder  = 8'h5f;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChLbrack = 8'h5b;
  localparam logic [7:0] ChRbrack = 8'h5d;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowN   = 8'h6e;
  localparam logic [7:0] ChLowT   = 8'h74;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

endpackage

// File: hdl/asrc_if.sv
// ----------------------------------------------------------------------------
// asrc_if
// request channels of the tokenizer: source bytes in, tokens out
// ----------------------------------------------------------------------------
interface asrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;

  modport source (output valid, source_byte, end_of_source, input ready);
  modport sink (input valid, source_byte, end_of_source, output ready);
endinterface

interface asrc_out_if #(
  parameter int OFFSET_WIDTH = 32,
  parameter int ROW_WIDTH    = 24
);
  logic                    valid;
  logic                    ready;
  logic [4:0]              token_kind;
  logic [2:0]              error_code;
  logic [OFFSET_WIDTH-1:0] span_start;
  logic [OFFSET_WIDTH-1:0] span_end;
  logic [ROW_WIDTH-1:0]    line_number;
  logic [OFFSET_WIDTH-1:0] column;
  logic                    has_escapes;
  logic                    last_of_run;

  modport source (output valid, token_kind, error_code, span_start, span_end, line_number,
                  column, has_escapes, last_of_run, input ready);
  modport sink (input valid, token_kind, error_code, span_start, span_end, line_number,
                column, has_escapes, last_of_run, output ready);
endinterface

// File: hdl/asrc_scan.sv
// ----------------------------------------------------------------------------
// asrc_scan
// scan state and per-byte token logic, up to three results per byte
// ----------------------------------------------------------------------------
module asrc_scan #(
  parameter int OFFSET_WIDTH = 32,
  parameter int ROW_WIDTH    = 24,
  localparam int ResW = 5 + 3 + 3 * OFFSET_WIDTH + ROW_WIDTH + 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [7:0]                byte_i,
  input  logic                      eos_i,
  input  logic                      accept_i,
  output logic [2:0][ResW-1:0]      res_o,
  output logic [1:0]                count_o
);

  typedef logic [OFFSET_WIDTH-1:0] ofs_t;
  typedef logic [ROW_WIDTH-1:0] row_t;

  typedef struct packed {
    logic [4:0] kind;
    logic [2:0] err;
    ofs_t       s;
    ofs_t       e;
    row_t       row;
    ofs_t       col;
    logic       esc;
    logic       last;
  } res_t;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUM, M_STR, M_STR_QUOTE, M_STR_BSLASH, M_STR_CR,
    M_CR, M_SLASH, M_GT, M_LCOMMENT, M_BCOMMENT, M_BSTAR, M_BCR
  } mode_e;

  mode_e      mode_q, mode_d;
  ofs_t       pos_q, pos_d, tstart_q, tstart_d, lstart_q, lstart_d, tcol_q, tcol_d;
  row_t       row_q, row_d, trow_q, trow_d;
  logic [1:0] tlen_q, tlen_d;
  logic       sdol_q, sdol_d, sdd_q, sdd_d, fzero_q, fzero_d;
  logic       dot_q, dot_d, qdbl_q, qdbl_d, esc_q, esc_d;

  ofs_t       p, e;
  logic [7:0] c, qch;
  logic       relex, str_go, blk_go;
  logic [1:0] n;
  res_t       res [3];
  logic [4:0] ikind;

  function automatic res_t mk(logic [4:0] k, logic [2:0] er, ofs_t s, ofs_t en, row_t r,
                              ofs_t cl, logic es);
    res_t x;
    x.kind = k;
    x.err  = er;
    x.s    = s;
    x.e    = en;
    x.row  = r;
    x.col  = cl;
    x.esc  = es;
    x.last = 1'b0;
    return x;
  endfunction

  always_comb begin
    c        = byte_i;
    p        = pos_q;
    e        = pos_q + ofs_t'(1);
    mode_d   = mode_q;
    pos_d    = e;
    tstart_d = tstart_q;
    lstart_d = lstart_q;
    tcol_d   = tcol_q;
    row_d    = row_q;
    trow_d   = trow_q;
    tlen_d   = tlen_q;
    sdol_d   = sdol_q;
    sdd_d    = sdd_q;
    fzero_d  = fzero_q;
    dot_d    = dot_q;
    qdbl_d   = qdbl_q;
    esc_d    = esc_q;
    relex    = 1'b0;
    str_go   = 1'b0;
    blk_go   = 1'b0;
    n        = 2'd0;
    qch      = qdbl_q ? asrc_pkg::ChDquote : asrc_pkg::ChSquote;
    for (int i = 0; i < 3; i++) res[i] = '0;
    ikind = asrc_pkg::TK_KEY;
    if (sdol_q && tlen_q == 2'd1) ikind = asrc_pkg::TK_DOLLAR;
    else if (sdol_q && tlen_q == 2'd2 && sdd_q) ikind = asrc_pkg::TK_DDOLLAR;

    case (mode_q)
      M_IDENT: begin
        if (asrc_pkg::is_letter(c) || asrc_pkg::is_digit(c) || c == asrc_pkg::ChUnder ||
            c == asrc_pkg::ChDollar) begin
          if (tlen_d == 2'd1) sdd_d = (c == asrc_pkg::ChDollar);
          if (tlen_d != 2'd3) tlen_d = tlen_d + 2'd1;
        end else if (c == asrc_pkg::ChColon) begin
          res[n] = mk(asrc_pkg::TK_LABEL, asrc_pkg::ERR_NONE, tstart_d, p, trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
          mode_d = M_IDLE;
        end else begin
          res[n] = mk(ikind, asrc_pkg::ERR_NONE, tstart_d, p, trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
          relex = 1'b1;
        end
      end
      M_NUM: begin
        if (c == asrc_pkg::ChDot && dot_d) begin
          res[n] = mk(asrc_pkg::TK_NUM, asrc_pkg::ERR_NONE, tstart_d, p, trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
          res[n] = mk(asrc_pkg::TK_ERROR, asrc_pkg::ERR_DOT2, p, e, row_d, p - lstart_d, 1'b0);
          n = n + 2'd1;
          mode_d = M_IDLE;
        end else if (c == asrc_pkg::ChDot || asrc_pkg::is_hex(c) ||
                     ((c == asrc_pkg::ChLowX || c == asrc_pkg::ChUpX) && tlen_d == 2'd1 &&
                      fzero_d)) begin
          if (c == asrc_pkg::ChDot) dot_d = 1'b1;
          if (tlen_d != 2'd3) tlen_d = tlen_d + 2'd1;
        end else if (c == asrc_pkg::ChLowH) begin
          res[n] = mk(asrc_pkg::TK_NUM, asrc_pkg::ERR_NONE, tstart_d, e, trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
          mode_d = M_IDLE;
        end else begin
          res[n] = mk(asrc_pkg::TK_NUM, asrc_pkg::ERR_NONE, tstart_d, p, trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
          relex = 1'b1;
        end
      end
      M_STR: str_go = 1'b1;
      M_STR_QUOTE: begin
        if (c == qch) begin
          esc_d  = 1'b1;
          mode_d = M_STR;
        end else begin
          res[n] = mk(asrc_pkg::TK_STR, asrc_pkg::ERR_NONE, tstart_d, p - ofs_t'(1), trow_d,
                      tcol_d, esc_d);
          n = n + 2'd1;
          relex = 1'b1;
        end
      end
      M_STR_BSLASH: begin
        esc_d = 1'b1;
        if (c == asrc_pkg::ChLowR || c == asrc_pkg::ChLowN || c == asrc_pkg::ChLowT) begin
          mode_d = M_STR;
        end else begin
          str_go = 1'b1;
        end
      end
      M_STR_CR: begin
        if (c == asrc_pkg::ChLf) begin
          lstart_d = e;
          mode_d   = M_STR;
        end else begin
          str_go = 1'b1;
        end
      end
      M_CR: begin
        if (c == asrc_pkg::ChLf) begin
          res[n] = mk(asrc_pkg::TK_LNEND, asrc_pkg::ERR_NONE, tstart_d, e, trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
          if (row_d != '1) row_d = row_d + row_t'(1);
          lstart_d = e;
          mode_d   = M_IDLE;
        end else begin
          res[n] = mk(asrc_pkg::TK_LNEND, asrc_pkg::ERR_NONE, tstart_d, tstart_d + ofs_t'(1),
                      trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
          if (row_d != '1) row_d = row_d + row_t'(1);
          lstart_d = tstart_d + ofs_t'(1);
          relex    = 1'b1;
        end
      end
      M_SLASH: begin
        if (c == asrc_pkg::ChSlash) begin
          mode_d = M_LCOMMENT;
        end else if (c == asrc_pkg::ChStar) begin
          mode_d = M_BCOMMENT;
        end else begin
          res[n] = mk(asrc_pkg::TK_DIV, asrc_pkg::ERR_NONE, tstart_d, tstart_d + ofs_t'(1),
                      trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
          relex = 1'b1;
        end
      end
      M_GT: begin
        if (c == asrc_pkg::ChGt) begin
          res[n] = mk(asrc_pkg::TK_RAR, asrc_pkg::ERR_NONE, tstart_d, e, trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
          mode_d = M_IDLE;
        end else begin
          res[n] = mk(asrc_pkg::TK_ERROR, asrc_pkg::ERR_LONE_GT, tstart_d,
                      tstart_d + ofs_t'(1), trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
          relex = 1'b1;
        end
      end
      M_LCOMMENT: begin
        if (c == asrc_pkg::ChCr || c == asrc_pkg::ChLf) relex = 1'b1;
      end
      M_BCOMMENT: blk_go = 1'b1;
      M_BSTAR: begin
        if (c == asrc_pkg::ChSlash) mode_d = M_IDLE;
        else blk_go = 1'b1;
      end
      M_BCR: begin
        if (c == asrc_pkg::ChLf) begin
          lstart_d = e;
          mode_d   = M_BCOMMENT;
        end else begin
          blk_go = 1'b1;
        end
      end
      default: relex = 1'b1;
    endcase

    if (str_go) begin
      mode_d = M_STR;
      if (c == qch) begin
        mode_d = M_STR_QUOTE;
      end else if (c == asrc_pkg::ChBslash) begin
        mode_d = M_STR_BSLASH;
      end else if (c == asrc_pkg::ChCr || c == asrc_pkg::ChLf) begin
        if (row_d != '1) row_d = row_d + row_t'(1);
        lstart_d = e;
        if (c == asrc_pkg::ChCr) mode_d = M_STR_CR;
      end
    end

    if (blk_go) begin
      mode_d = M_BCOMMENT;
      if (c == asrc_pkg::ChStar) begin
        mode_d = M_BSTAR;
      end else if (c == asrc_pkg::ChCr || c == asrc_pkg::ChLf) begin
        if (row_d != '1) row_d = row_d + row_t'(1);
        lstart_d = e;
        if (c == asrc_pkg::ChCr) mode_d = M_BCR;
      end
    end

    if (relex) begin
      mode_d = M_IDLE;
      if (asrc_pkg::is_letter(c) || c == asrc_pkg::ChUnder || c == asrc_pkg::ChDollar ||
          asrc_pkg::is_digit(c) || c == asrc_pkg::ChCr || c == asrc_pkg::ChSlash ||
          c == asrc_pkg::ChGt) begin
        tstart_d = p;
        trow_d   = row_d;
        tcol_d   = p - lstart_d;
      end
      if (asrc_pkg::is_letter(c) || c == asrc_pkg::ChUnder || c == asrc_pkg::ChDollar) begin
        tlen_d = 2'd1;
        sdol_d = (c == asrc_pkg::ChDollar);
        sdd_d  = 1'b0;
        mode_d = M_IDENT;
      end else if (asrc_pkg::is_digit(c)) begin
        tlen_d  = 2'd1;
        fzero_d = (c == asrc_pkg::ChZero);
        dot_d   = 1'b0;
        mode_d  = M_NUM;
      end else begin
        case (c)
          asrc_pkg::ChCr: mode_d = M_CR;
          asrc_pkg::ChLf: begin
            res[n] = mk(asrc_pkg::TK_LNEND, asrc_pkg::ERR_NONE, p, e, row_d, p - lstart_d, 1'b0);
            n = n + 2'd1;
            if (row_d != '1) row_d = row_d + row_t'(1);
            lstart_d = e;
          end
          asrc_pkg::ChSpace, asrc_pkg::ChTab: ;
          asrc_pkg::ChSemi:  mode_d = M_LCOMMENT;
          asrc_pkg::ChSlash: mode_d = M_SLASH;
          asrc_pkg::ChGt:    mode_d = M_GT;
          asrc_pkg::ChSquote, asrc_pkg::ChDquote: begin
            tstart_d = e;
            trow_d   = row_d;
            tcol_d   = e - lstart_d;
            qdbl_d   = (c == asrc_pkg::ChDquote);
            esc_d    = 1'b0;
            mode_d   = M_STR;
          end
          default: begin
            res[n] = mk(asrc_pkg::TK_ERROR, asrc_pkg::ERR_INVALID, p, e, row_d, p - lstart_d,
                        1'b0);
            case (c)
              asrc_pkg::ChComma:  res[n].kind = asrc_pkg::TK_SEP;
              asrc_pkg::ChDot:    res[n].kind = asrc_pkg::TK_DOT;
              asrc_pkg::ChLbrack: res[n].kind = asrc_pkg::TK_LBRACK;
              asrc_pkg::ChRbrack: res[n].kind = asrc_pkg::TK_RBRACK;
              asrc_pkg::ChLparen: res[n].kind = asrc_pkg::TK_LPAREN;
              asrc_pkg::ChRparen: res[n].kind = asrc_pkg::TK_RPAREN;
              asrc_pkg::ChPlus:   res[n].kind = asrc_pkg::TK_ADD;
              asrc_pkg::ChMinus:  res[n].kind = asrc_pkg::TK_SUB;
              asrc_pkg::ChStar:   res[n].kind = asrc_pkg::TK_MUL;
              asrc_pkg::ChColon:  res[n].kind = asrc_pkg::TK_COLON;
              default:            res[n].kind = asrc_pkg::TK_ERROR;
            endcase
            if (res[n].kind != asrc_pkg::TK_ERROR) res[n].err = asrc_pkg::ERR_NONE;
            n = n + 2'd1;
          end
        endcase
      end
    end

    // flush on the final byte
    if (eos_i) begin
      ikind = asrc_pkg::TK_KEY;
      if (sdol_d && tlen_d == 2'd1) ikind = asrc_pkg::TK_DOLLAR;
      else if (sdol_d && tlen_d == 2'd2 && sdd_d) ikind = asrc_pkg::TK_DDOLLAR;
      case (mode_d)
        M_IDENT: begin
          res[n] = mk(ikind, asrc_pkg::ERR_NONE, tstart_d, e, trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
        end
        M_NUM: begin
          res[n] = mk(asrc_pkg::TK_NUM, asrc_pkg::ERR_NONE, tstart_d, e, trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
        end
        M_STR, M_STR_BSLASH, M_STR_CR: begin
          res[n] = mk(asrc_pkg::TK_ERROR, asrc_pkg::ERR_UNTERM, tstart_d, e, trow_d, tcol_d,
                      1'b0);
          n = n + 2'd1;
        end
        M_STR_QUOTE: begin
          res[n] = mk(asrc_pkg::TK_STR, asrc_pkg::ERR_NONE, tstart_d, p, trow_d, tcol_d, esc_d);
          n = n + 2'd1;
        end
        M_CR: begin
          res[n] = mk(asrc_pkg::TK_LNEND, asrc_pkg::ERR_NONE, tstart_d, tstart_d + ofs_t'(1),
                      trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
          if (row_d != '1) row_d = row_d + row_t'(1);
          lstart_d = tstart_d + ofs_t'(1);
        end
        M_SLASH: begin
          res[n] = mk(asrc_pkg::TK_DIV, asrc_pkg::ERR_NONE, tstart_d, tstart_d + ofs_t'(1),
                      trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
        end
        M_GT: begin
          res[n] = mk(asrc_pkg::TK_ERROR, asrc_pkg::ERR_LONE_GT, tstart_d,
                      tstart_d + ofs_t'(1), trow_d, tcol_d, 1'b0);
          n = n + 2'd1;
        end
        default: ;
      endcase
      if (n != 2'd3) begin
        res[n] = mk(asrc_pkg::TK_END, asrc_pkg::ERR_NONE, e, e, row_d, e - lstart_d, 1'b0);
        n = n + 2'd1;
      end
      mode_d   = M_IDLE;
      pos_d    = '0;
      tstart_d = '0;
      lstart_d = '0;
      tcol_d   = '0;
      row_d    = '0;
      trow_d   = '0;
      tlen_d   = '0;
      sdol_d   = 1'b0;
      sdd_d    = 1'b0;
      fzero_d  = 1'b0;
      dot_d    = 1'b0;
      qdbl_d   = 1'b0;
      esc_d    = 1'b0;
    end

    if (n != 2'd0) res[n - 2'd1].last = 1'b1;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) res_o[i] = res[i];
    count_o = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      pos_q    <= '0;
      tstart_q <= '0;
      lstart_q <= '0;
      tcol_q   <= '0;
      row_q    <= '0;
      trow_q   <= '0;
      tlen_q   <= '0;
      sdol_q   <= 1'b0;
      sdd_q    <= 1'b0;
      fzero_q  <= 1'b0;
      dot_q    <= 1'b0;
      qdbl_q   <= 1'b0;
      esc_q    <= 1'b0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      tstart_q <= tstart_d;
      lstart_q <= lstart_d;
      tcol_q   <= tcol_d;
      row_q    <= row_d;
      trow_q   <= trow_d;
      tlen_q   <= tlen_d;
      sdol_q   <= sdol_d;
      sdd_q    <= sdd_d;
      fzero_q  <= fzero_d;
      dot_q    <= dot_d;
      qdbl_q   <= qdbl_d;
      esc_q    <= esc_d;
    end
  end

endmodule

// File: hdl/assembly_source_tokenizer_top.sv
// ----------------------------------------------------------------------------
// assembly_source_tokenizer_top
// streaming lexer for assembly source, one byte per request in, tokens out
//
//   channel  dir  payload
//   src_i    in   source_byte, end_of_source
//   tok_o    out  token_kind, error_code, span_start, span_end, line_number,
//                 column, has_escapes, last_of_run
//
// a byte's zero to three tokens leave one per cycle while tok_o.ready is high,
// from a three-entry result buffer, so bytes with one token run at one a cycle
// a new byte is taken while the last buffered token of the previous one leaves
// reset clears the scan state and empties the buffer
// ----------------------------------------------------------------------------
module assembly_source_tokenizer_top #(
  parameter int OFFSET_WIDTH = 32,
  parameter int ROW_WIDTH    = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  asrc_in_if.sink   src_i,
  asrc_out_if.source tok_o
);

  localparam int ResW = 5 + 3 + 3 * OFFSET_WIDTH + ROW_WIDTH + 2;

  typedef struct packed {
    logic [4:0]              kind;
    logic [2:0]              err;
    logic [OFFSET_WIDTH-1:0] s;
    logic [OFFSET_WIDTH-1:0] e;
    logic [ROW_WIDTH-1:0]    row;
    logic [OFFSET_WIDTH-1:0] col;
    logic                    esc;
    logic                    last;
  } res_t;

  logic [2:0][ResW-1:0] scan_res;
  logic [1:0]           scan_n;
  res_t                 buf_q [3];
  res_t                 head;
  logic [1:0]           cnt_q, rd_q;
  logic                 empty, pop, in_acc;

  asrc_scan #(
    .OFFSET_WIDTH(OFFSET_WIDTH),
    .ROW_WIDTH   (ROW_WIDTH)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (src_i.source_byte),
    .eos_i   (src_i.end_of_source),
    .accept_i(in_acc),
    .res_o   (scan_res),
    .count_o (scan_n)
  );

  assign empty       = (rd_q == cnt_q);
  assign pop         = tok_o.valid && tok_o.ready;
  assign src_i.ready = empty || (pop && (rd_q + 2'd1 == cnt_q));
  assign in_acc      = src_i.valid && src_i.ready;
  assign head        = (rd_q == 2'd3) ? buf_q[0] : buf_q[rd_q];

  assign tok_o.valid       = !empty;
  assign tok_o.token_kind  = head.kind;
  assign tok_o.error_code  = head.err;
  assign tok_o.span_start  = head.s;
  assign tok_o.span_end    = head.e;
  assign tok_o.line_number = head.row;
  assign tok_o.column      = head.col;
  assign tok_o.has_escapes = head.esc;
  assign tok_o.last_of_run = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 2'd0;
    end else if (in_acc) begin
      cnt_q <= scan_n;
      rd_q  <= 2'd0;
    end else if (pop) begin
      rd_q <= rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) buf_q[i] <= res_t'(scan_res[i]);
    end
  end

  a_valid_has_entries : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_o.valid |-> (cnt_q != 2'd0 && rd_q < cnt_q))
    else $error("token shown from an empty buffer");

  a_last_marks_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_o.valid |-> (tok_o.last_of_run == (rd_q + 2'd1 == cnt_q)))
    else $error("last_of_run out of step with buffer");

  a_accept_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && scan_n != 2'd0) |=> (tok_o.valid && rd_q == 2'd0))
    else $error("tokens of an accepted byte not shown");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (empty || (pop && rd_q + 2'd1 == cnt_q)))
    else $error("byte taken over pending tokens");

endmodule

// File: verif/asrc_token_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// asrc_token_checker
// watches the byte and token channels of the tokenizer, predicts the tokens
// each accepted byte causes and compares every accepted token in order
// ----------------------------------------------------------------------------
module asrc_token_checker (
  input  logic clk_i,
  input  logic rst_ni,
  asrc_in_if   src_i,
  asrc_out_if  tok_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct {
    asrc_pkg::tok_kind_e kind;
    asrc_pkg::tok_err_e  err;
    logic [31:0]         span_start;
    logic [31:0]         span_end;
    logic [23:0]         row;
    logic [31:0]         col;
    logic                esc;
    logic                last;
  } token_t;

  localparam int ScIdle = 0, ScIdent = 1, ScNum = 2, ScStr = 3, ScStrQuote = 4,
                 ScStrBslash = 5, ScStrCr = 6, ScCr = 7, ScSlash = 8, ScGt = 9,
                 ScLineCmt = 10, ScBlockCmt = 11, ScBlockStar = 12, ScBlockCr = 13;

  token_t      expected_tokens[$];
  token_t      byte_tokens[$];
  int          mode;
  logic [31:0] pos, tok_start, row_origin, tok_col;
  logic [23:0] row, tok_row;
  int          tok_len;
  logic        dollar_first, dollar_second, zero_first, dot_seen, dquote, esc_seen;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_dec(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hexc(logic [7:0] c);
    return is_dec(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  task automatic clear_scan();
    mode = ScIdle; pos = 0; tok_start = 0; row_origin = 0; row = 0; tok_len = 0;
    dollar_first = 0; dollar_second = 0; zero_first = 0; dot_seen = 0;
    dquote = 0; esc_seen = 0; tok_row = 0; tok_col = 0;
  endtask

  task automatic push_token(asrc_pkg::tok_kind_e k, asrc_pkg::tok_err_e e, logic [31:0] s,
                            logic [31:0] f, logic [23:0] r, logic [31:0] c, logic x);
    token_t t;
    t.kind = k; t.err = e; t.span_start = s; t.span_end = f;
    t.row = r; t.col = c; t.esc = x; t.last = 0;
    if (byte_tokens.size() < 3) byte_tokens.push_back(t);
  endtask

  task automatic token_here(asrc_pkg::tok_kind_e k, asrc_pkg::tok_err_e e, logic [31:0] p);
    push_token(k, e, p, p + 1, row, p - row_origin, 0);
  endtask

  task automatic token_pending(asrc_pkg::tok_kind_e k, asrc_pkg::tok_err_e e, logic [31:0] f,
                               logic x);
    push_token(k, e, tok_start, f, tok_row, tok_col, x);
  endtask

  task automatic open_token(logic [31:0] s);
    tok_start = s; tok_row = row; tok_col = s - row_origin;
  endtask

  task automatic next_row(logic [31:0] nxt);
    if (row != 24'hffffff) row++;
    row_origin = nxt;
  endtask

  function automatic asrc_pkg::tok_kind_e word_kind();
    if (dollar_first && tok_len == 1) return asrc_pkg::TK_DOLLAR;
    if (dollar_first && tok_len == 2 && dollar_second) return asrc_pkg::TK_DDOLLAR;
    return asrc_pkg::TK_KEY;
  endfunction

  task automatic fresh_byte(logic [7:0] c, logic [31:0] p);
    mode = ScIdle;
    if (is_alpha(c) || c == asrc_pkg::ChUnder || c == asrc_pkg::ChDollar) begin
      open_token(p); tok_len = 1; dollar_first = (c == asrc_pkg::ChDollar);
      dollar_second = 0; mode = ScIdent;
    end else if (is_dec(c)) begin
      open_token(p); tok_len = 1; zero_first = (c == asrc_pkg::ChZero); dot_seen = 0;
      mode = ScNum;
    end else begin
      case (c)
        asrc_pkg::ChCr: begin open_token(p); mode = ScCr; end
        asrc_pkg::ChLf: begin
          token_here(asrc_pkg::TK_LNEND, asrc_pkg::ERR_NONE, p); next_row(p + 1);
        end
        asrc_pkg::ChSpace, asrc_pkg::ChTab: ;
        asrc_pkg::ChComma:  token_here(asrc_pkg::TK_SEP, asrc_pkg::ERR_NONE, p);
        asrc_pkg::ChDot:    token_here(asrc_pkg::TK_DOT, asrc_pkg::ERR_NONE, p);
        asrc_pkg::ChLbrack: token_here(asrc_pkg::TK_LBRACK, asrc_pkg::ERR_NONE, p);
        asrc_pkg::ChRbrack: token_here(asrc_pkg::TK_RBRACK, asrc_pkg::ERR_NONE, p);
        asrc_pkg::ChLparen: token_here(asrc_pkg::TK_LPAREN, asrc_pkg::ERR_NONE, p);
        asrc_pkg::ChRparen: token_here(asrc_pkg::TK_RPAREN, asrc_pkg::ERR_NONE, p);
        asrc_pkg::ChPlus:   token_here(asrc_pkg::TK_ADD, asrc_pkg::ERR_NONE, p);
        asrc_pkg::ChMinus:  token_here(asrc_pkg::TK_SUB, asrc_pkg::ERR_NONE, p);
        asrc_pkg::ChStar:   token_here(asrc_pkg::TK_MUL, asrc_pkg::ERR_NONE, p);
        asrc_pkg::ChColon:  token_here(asrc_pkg::TK_COLON, asrc_pkg::ERR_NONE, p);
        asrc_pkg::ChSemi:   mode = ScLineCmt;
        asrc_pkg::ChSlash:  begin open_token(p); mode = ScSlash; end
        asrc_pkg::ChGt:     begin open_token(p); mode = ScGt; end
        asrc_pkg::ChSquote, asrc_pkg::ChDquote: begin
          open_token(p + 1); dquote = (c == asrc_pkg::ChDquote); esc_seen = 0; mode = ScStr;
        end
        default: token_here(asrc_pkg::TK_ERROR, asrc_pkg::ERR_INVALID, p);
      endcase
    end
  endtask

  task automatic string_byte(logic [7:0] c, logic [31:0] p);
    mode = ScStr;
    if (c == (dquote ? asrc_pkg::ChDquote : asrc_pkg::ChSquote)) mode = ScStrQuote;
    else if (c == asrc_pkg::ChBslash) mode = ScStrBslash;
    else if (c == asrc_pkg::ChCr) begin next_row(p + 1); mode = ScStrCr; end
    else if (c == asrc_pkg::ChLf) next_row(p + 1);
  endtask

  task automatic comment_byte(logic [7:0] c, logic [31:0] p);
    mode = ScBlockCmt;
    if (c == asrc_pkg::ChStar) mode = ScBlockStar;
    else if (c == asrc_pkg::ChCr) begin next_row(p + 1); mode = ScBlockCr; end
    else if (c == asrc_pkg::ChLf) next_row(p + 1);
  endtask

  task automatic scan_byte(logic [7:0] c, logic [31:0] p);
    case (mode)
      ScIdent:
        if (is_alpha(c) || is_dec(c) || c == asrc_pkg::ChUnder ||
            c == asrc_pkg::ChDollar) begin
          if (tok_len == 1) dollar_second = (c == asrc_pkg::ChDollar);
          if (tok_len < 3) tok_len++;
        end else if (c == asrc_pkg::ChColon) begin
          token_pending(asrc_pkg::TK_LABEL, asrc_pkg::ERR_NONE, p, 0); mode = ScIdle;
        end else begin
          token_pending(word_kind(), asrc_pkg::ERR_NONE, p, 0); fresh_byte(c, p);
        end
      ScNum:
        if (c == asrc_pkg::ChDot && dot_seen) begin
          token_pending(asrc_pkg::TK_NUM, asrc_pkg::ERR_NONE, p, 0);
          token_here(asrc_pkg::TK_ERROR, asrc_pkg::ERR_DOT2, p);
          mode = ScIdle;
        end else if (c == asrc_pkg::ChDot || is_hexc(c) ||
                     ((c == asrc_pkg::ChLowX || c == asrc_pkg::ChUpX) && tok_len == 1 &&
                      zero_first)) begin
          if (c == asrc_pkg::ChDot) dot_seen = 1;
          if (tok_len < 3) tok_len++;
        end else if (c == asrc_pkg::ChLowH) begin
          token_pending(asrc_pkg::TK_NUM, asrc_pkg::ERR_NONE, p + 1, 0); mode = ScIdle;
        end else begin
          token_pending(asrc_pkg::TK_NUM, asrc_pkg::ERR_NONE, p, 0); fresh_byte(c, p);
        end
      ScStr: string_byte(c, p);
      ScStrQuote:
        if (c == (dquote ? asrc_pkg::ChDquote : asrc_pkg::ChSquote)) begin
          esc_seen = 1; mode = ScStr;
        end else begin
          token_pending(asrc_pkg::TK_STR, asrc_pkg::ERR_NONE, p - 1, esc_seen);
          fresh_byte(c, p);
        end
      ScStrBslash: begin
        esc_seen = 1;
        if (c == asrc_pkg::ChLowR || c == asrc_pkg::ChLowN || c == asrc_pkg::ChLowT)
          mode = ScStr;
        else string_byte(c, p);
      end
      ScStrCr:
        if (c == asrc_pkg::ChLf) begin row_origin = p + 1; mode = ScStr; end
        else string_byte(c, p);
      ScCr:
        if (c == asrc_pkg::ChLf) begin
          token_pending(asrc_pkg::TK_LNEND, asrc_pkg::ERR_NONE, p + 1, 0); next_row(p + 1);
          mode = ScIdle;
        end else begin
          token_pending(asrc_pkg::TK_LNEND, asrc_pkg::ERR_NONE, tok_start + 1, 0);
          next_row(tok_start + 1);
          fresh_byte(c, p);
        end
      ScSlash:
        if (c == asrc_pkg::ChSlash) mode = ScLineCmt;
        else if (c == asrc_pkg::ChStar) mode = ScBlockCmt;
        else begin
          token_pending(asrc_pkg::TK_DIV, asrc_pkg::ERR_NONE, tok_start + 1, 0);
          fresh_byte(c, p);
        end
      ScGt:
        if (c == asrc_pkg::ChGt) begin
          token_pending(asrc_pkg::TK_RAR, asrc_pkg::ERR_NONE, p + 1, 0); mode = ScIdle;
        end else begin
          token_pending(asrc_pkg::TK_ERROR, asrc_pkg::ERR_LONE_GT, tok_start + 1, 0);
          fresh_byte(c, p);
        end
      ScLineCmt: if (c == asrc_pkg::ChCr || c == asrc_pkg::ChLf) fresh_byte(c, p);
      ScBlockCmt: comment_byte(c, p);
      ScBlockStar: if (c == asrc_pkg::ChSlash) mode = ScIdle; else comment_byte(c, p);
      ScBlockCr:
        if (c == asrc_pkg::ChLf) begin row_origin = p + 1; mode = ScBlockCmt; end
        else comment_byte(c, p);
      default: fresh_byte(c, p);
    endcase
  endtask

  task automatic flush_source(logic [31:0] p);
    logic [31:0] f;
    f = p + 1;
    case (mode)
      ScIdent: token_pending(word_kind(), asrc_pkg::ERR_NONE, f, 0);
      ScNum: token_pending(asrc_pkg::TK_NUM, asrc_pkg::ERR_NONE, f, 0);
      ScStr, ScStrBslash, ScStrCr:
        token_pending(asrc_pkg::TK_ERROR, asrc_pkg::ERR_UNTERM, f, 0);
      ScStrQuote: token_pending(asrc_pkg::TK_STR, asrc_pkg::ERR_NONE, p, esc_seen);
      ScCr: begin
        token_pending(asrc_pkg::TK_LNEND, asrc_pkg::ERR_NONE, tok_start + 1, 0);
        next_row(tok_start + 1);
      end
      ScSlash: token_pending(asrc_pkg::TK_DIV, asrc_pkg::ERR_NONE, tok_start + 1, 0);
      ScGt: token_pending(asrc_pkg::TK_ERROR, asrc_pkg::ERR_LONE_GT, tok_start + 1, 0);
      default: ;
    endcase
    push_token(asrc_pkg::TK_END, asrc_pkg::ERR_NONE, f, f, row, f - row_origin, 0);
  endtask

  task automatic predict_tokens(logic [7:0] c, logic eos);
    logic [31:0] p;
    p = pos;
    byte_tokens.delete();
    scan_byte(c, p);
    pos = p + 1;
    if (eos) begin
      flush_source(p);
      clear_scan();
    end
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1;
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endtask

  task automatic compare_token();
    token_t e;
    if (expected_tokens.size() == 0) begin
      $display("%0t: unexpected token kind %0d", $time, tok_i.token_kind);
      fail_count_o++;
      return;
    end
    e = expected_tokens.pop_front();
    if (tok_i.token_kind !== e.kind) begin
      $display("%0t: kind exp %0d act %0d", $time, e.kind, tok_i.token_kind);
      fail_count_o++;
    end
    if (tok_i.error_code !== e.err) begin
      $display("%0t: error_code exp %0d act %0d", $time, e.err, tok_i.error_code);
      fail_count_o++;
    end
    if (tok_i.span_start !== e.span_start) begin
      $display("%0t: span_start exp %0d act %0d", $time, e.span_start, tok_i.span_start);
      fail_count_o++;
    end
    if (tok_i.span_end !== e.span_end) begin
      $display("%0t: span_end exp %0d act %0d", $time, e.span_end, tok_i.span_end);
      fail_count_o++;
    end
    if (tok_i.line_number !== e.row) begin
      $display("%0t: line_number exp %0d act %0d", $time, e.row, tok_i.line_number);
      fail_count_o++;
    end
    if (tok_i.column !== e.col) begin
      $display("%0t: column exp %0d act %0d", $time, e.col, tok_i.column);
      fail_count_o++;
    end
    if (tok_i.has_escapes !== e.esc) begin
      $display("%0t: has_escapes exp %0d act %0d", $time, e.esc, tok_i.has_escapes);
      fail_count_o++;
    end
    if (tok_i.last_of_run !== e.last) begin
      $display("%0t: last_of_run exp %0d act %0d", $time, e.last, tok_i.last_of_run);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_scan();
      expected_tokens.delete();
      fail_count_o = 0;
    end else begin
      if (tok_i.valid === 1'b1 && tok_i.ready === 1'b1) compare_token();
      if (src_i.valid === 1'b1 && src_i.ready === 1'b1)
        predict_tokens(src_i.source_byte, src_i.end_of_source);
    end
    pending_o = expected_tokens.size();
  end

endmodule

// File: verif/assembly_source_tokenizer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// assembly_source_tokenizer_top_test
// drives directed and random assembly source through the tokenizer with
// random idling on both sides and a checker predicting every token
// ----------------------------------------------------------------------------
module assembly_source_tokenizer_top_test;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int          fail_count, pending, idle_cycles, sent;
  logic        calm, hold_req, hold_done, drain_done;
  logic [7:0]  text_q[$];

  asrc_in_if  src_if ();
  asrc_out_if tok_if ();

  assembly_source_tokenizer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .src_i  (src_if),
    .tok_o  (tok_if)
  );

  asrc_token_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_i        (src_if),
    .tok_i        (tok_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((src_if.valid && src_if.ready) || (tok_if.valid && tok_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == 3000) begin
      $display("status: fail");
      $finish;
    end
  end

  // token receiver
  initial begin
    tok_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        tok_if.ready = 1'b0;
        repeat (60) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(3) == 0) begin
        tok_if.ready = 1'b0;
        repeat ($urandom_range(4)) @(negedge clk_i);
      end else begin
        tok_if.ready = 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic eos);
    if (!calm && $urandom_range(4) == 0) begin
      src_if.valid = 1'b0;
      repeat ($urandom_range(5, 1)) @(negedge clk_i);
    end
    src_if.source_byte   = b;
    src_if.end_of_source = eos;
    src_if.valid         = 1'b1;
    do @(posedge clk_i); while (!src_if.ready);
    @(negedge clk_i);
    src_if.valid = 1'b0;
    sent++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic send_source();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic add_random_token();
    int         n;
    logic [7:0] q;
    case ($urandom_range(10))
      0, 1: begin
        n = $urandom_range(4, 1);
        if ($urandom_range(3) == 0) text_q.push_back(asrc_pkg::ChDollar);
        repeat (n) text_q.push_back($urandom_range(2) == 0 ? asrc_pkg::ChDollar :
                                    8'(8'h61 + $urandom_range(25)));
        if ($urandom_range(3) == 0) text_q.push_back(asrc_pkg::ChColon);
      end
      2: begin
        text_q.push_back($urandom_range(1) ? asrc_pkg::ChZero :
                         8'(8'h31 + $urandom_range(8)));
        if ($urandom_range(2) == 0)
          text_q.push_back($urandom_range(1) ? asrc_pkg::ChLowX : asrc_pkg::ChUpX);
        repeat ($urandom_range(4)) begin
          case ($urandom_range(3))
            0: text_q.push_back(asrc_pkg::ChDot);
            1: text_q.push_back(8'(8'h41 + $urandom_range(5)));
            default: text_q.push_back(8'(asrc_pkg::ChZero + $urandom_range(9)));
          endcase
        end
        if ($urandom_range(2) == 0) text_q.push_back(asrc_pkg::ChLowH);
      end
      3: begin
        q = $urandom_range(1) ? asrc_pkg::ChDquote : asrc_pkg::ChSquote;
        text_q.push_back(q);
        repeat ($urandom_range(5)) begin
          case ($urandom_range(6))
            0: begin text_q.push_back(q); text_q.push_back(q); end
            1: begin
              text_q.push_back(asrc_pkg::ChBslash);
              text_q.push_back($urandom_range(1) ? asrc_pkg::ChLowN :
                               8'($urandom_range(255)));
            end
            2: text_q.push_back($urandom_range(1) ? asrc_pkg::ChCr : asrc_pkg::ChLf);
            default: text_q.push_back(8'(8'h61 + $urandom_range(25)));
          endcase
        end
        if ($urandom_range(5) != 0) text_q.push_back(q);
      end
      4: begin
        case ($urandom_range(2))
          0: text_q.push_back(asrc_pkg::ChCr);
          1: text_q.push_back(asrc_pkg::ChLf);
          default: begin text_q.push_back(asrc_pkg::ChCr); text_q.push_back(asrc_pkg::ChLf); end
        endcase
      end
      5: add_text(",.[]()+-*:/>");
      6: begin
        case ($urandom_range(2))
          0: add_text("; note");
          1: add_text("// x");
          default: add_text("/* a*\015\nb */");
        endcase
        text_q.push_back(asrc_pkg::ChLf);
      end
      7: text_q.push_back(8'($urandom_range(255)));
      8: add_text(">>");
      default: text_q.push_back($urandom_range(1) ? asrc_pkg::ChSpace : asrc_pkg::ChTab);
    endcase
  endtask

  initial begin
    rst_ni = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    sent = 0;
    src_if.valid = 1'b0;
    src_if.source_byte = 8'h00;
    src_if.end_of_source = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_text("a$: $ $$ _q 0x1F.2h 1.2.3 > >>/ ");
    text_q.push_back(8'hff);
    text_q.push_back(8'h00);
    add_text("\"a\"\"\\n\\q\" ");
    text_q.push_back(asrc_pkg::ChCr);
    text_q.push_back(asrc_pkg::ChLf);
    text_q.push_back(asrc_pkg::ChCr);
    add_text("/*\015\n*/'x");
    send_source();
    add_text("[x](y)+-*:,.; c\n>");
    send_source();
    add_text("/* open");
    send_source();
    add_text("7");
    send_source();

    while (sent < 160) begin
      if (!hold_done && sent > 85) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && sent > 115) begin
        wait (pending == 0);
        drain_done = 1'b1;
      end
      if (sent > 135) calm = 1'b1;
      add_random_token();
      if (sent > 155 || $urandom_range(12) == 0) begin
        send_source();
      end else begin
        for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], 1'b0);
        text_q.delete();
      end
    end
    add_text("end");
    send_source();
    src_if.valid = 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
